### rtl/smt_pkg.sv
// shared constants and codes for the sorted mark table
package smt_pkg;

	localparam int TABLE_DEPTH   = 64;
	localparam int POSITION_BITS = 24;
	localparam int ADDR_W        = $clog2(TABLE_DEPTH);
	localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
	localparam int SEQ_W         = $clog2(TABLE_DEPTH / 2 + 1);

	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	// result word: status, found_position, mark_count, sequence_count
	localparam int OUT_BITS   = STATUS_W + POSITION_BITS + CNT_W + SEQ_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int IN_DATA_W  = ((POSITION_BITS + 7) / 8) * 8;

	localparam int FOUND_LSB = STATUS_W;
	localparam int COUNT_LSB = FOUND_LSB + POSITION_BITS;
	localparam int SEQ_LSB   = COUNT_LSB + CNT_W;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXACT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PREV   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NEXT   = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

### rtl/smt_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module smt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/sorted_mark_table.sv
// sorted mark table: ascending position table with insert and neighbor search
//
//   group   dir   tdata                          tuser
//   s_*     in    position                       kind
//   m_*     out   status, found_position,        -
//                 mark_count, sequence_count
//
// one command at a time; an insert shifts each larger mark up one slot and a
// search reads marks in turn, both through the single read port of the position
// ram. a dropped insert or a search of an empty table skips the ram and goes
// straight to the result state.
// a new command is taken while a result still waits in the output register;
// its own result then holds in the last cycle until that register frees.
// reset empties the table at once; ram contents are never cleared.
module sorted_mark_table (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [smt_pkg::IN_DATA_W-1:0]         s_tdata,  // position
	input  logic [smt_pkg::KIND_W-1:0]            s_tuser,  // kind
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// status, found_position, mark_count, sequence_count, zero fill
	output logic [smt_pkg::OUT_DATA_W-1:0]        m_tdata
);

	import smt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_PUT,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t                  state_q;
	logic [KIND_W-1:0]       kind_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        distinct_q;
	logic                    min_zero_q;
	logic [ADDR_W-1:0]       slot_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [CNT_W-1:0]        left_q;
	logic [STATUS_W-1:0]     status_q;
	logic [POSITION_BITS-1:0] found_q;
	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;

	logic                    in_xfer;
	logic [KIND_W-1:0]       in_kind;
	logic [POSITION_BITS-1:0] in_pos;
	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [POSITION_BITS-1:0] ram_wdata;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [POSITION_BITS-1:0] ram_rdata;
	logic [ADDR_W-1:0]       last_addr;
	logic                    scan_hit;
	logic [CNT_W-1:0]        seq_half;
	logic [SEQ_W-1:0]        seq_count;

	assign in_kind   = s_tuser;
	assign in_pos    = s_tdata[POSITION_BITS-1:0];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign last_addr = ADDR_W'(count_q - CNT_W'(1));

	// first read goes out with the accepted command, later ones from the loop
	always_comb begin
		case (state_q)
			ST_IDLE: ram_raddr = (in_kind == KIND_INSERT || in_kind == KIND_PREV) ?
				last_addr : '0;
			ST_INS:  ram_raddr = slot_q - ADDR_W'(2);
			ST_SCAN: ram_raddr = addr_q;
			default: ram_raddr = '0;
		endcase
	end

	// shift larger marks up one slot, then drop the new one in the gap
	assign ram_we    = (state_q == ST_INS) || (state_q == ST_PUT);
	assign ram_waddr = slot_q;
	assign ram_wdata = (state_q == ST_INS && ram_rdata > pos_q) ? ram_rdata : pos_q;

	always_comb begin
		case (kind_q)
			KIND_EXACT: scan_hit = (ram_rdata >= pos_q);
			KIND_PREV:  scan_hit = (ram_rdata < pos_q);
			KIND_NEXT:  scan_hit = (ram_rdata > pos_q);
			default:    scan_hit = 1'b0;
		endcase
	end

	// pairs of distinct marks, an odd one left over counts too; a lone mark at zero counts none
	assign seq_half  = CNT_W'((distinct_q + CNT_W'(1)) >> 1);
	assign seq_count = (distinct_q == CNT_W'(1) && min_zero_q) ? '0 : seq_half[SEQ_W-1:0];

	smt_ram #(
		.WIDTH(POSITION_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			distinct_q  <= '0;
			min_zero_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// the last state refills the output register itself
			if (out_valid_q && m_tready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						kind_q <= in_kind;
						pos_q  <= in_pos;
						if (in_kind == KIND_INSERT) begin
							if (count_q == CNT_W'(TABLE_DEPTH)) begin
								status_q <= STATUS_FULL;
								found_q  <= '0;
								state_q  <= ST_FIN;
							end else if (count_q == '0) begin
								slot_q  <= '0;
								state_q <= ST_PUT;
							end else begin
								slot_q  <= ADDR_W'(count_q);
								state_q <= ST_INS;
							end
						end else if (count_q == '0) begin
							status_q <= STATUS_NONE;
							found_q  <= '0;
							state_q  <= ST_FIN;
						end else begin
							left_q  <= count_q - CNT_W'(1);
							addr_q  <= (in_kind == KIND_PREV) ? last_addr - ADDR_W'(1) :
								ADDR_W'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_INS: begin
					if (ram_rdata > pos_q) begin
						slot_q <= slot_q - ADDR_W'(1);
						if (slot_q == ADDR_W'(1)) begin
							state_q <= ST_PUT;
						end
					end else begin
						// only the mark just below can equal the new one
						if (ram_rdata != pos_q) begin
							distinct_q <= distinct_q + CNT_W'(1);
						end
						count_q  <= count_q + CNT_W'(1);
						status_q <= STATUS_OK;
						found_q  <= pos_q;
						state_q  <= ST_FIN;
					end
				end
				ST_PUT: begin
					// new smallest mark, everything above is strictly larger
					distinct_q <= distinct_q + CNT_W'(1);
					count_q    <= count_q + CNT_W'(1);
					min_zero_q <= (pos_q == '0);
					status_q   <= STATUS_OK;
					found_q    <= pos_q;
					state_q    <= ST_FIN;
				end
				ST_SCAN: begin
					if (scan_hit) begin
						if (kind_q == KIND_EXACT && ram_rdata != pos_q) begin
							status_q <= STATUS_NONE;
							found_q  <= '0;
						end else begin
							status_q <= STATUS_OK;
							found_q  <= ram_rdata;
						end
						state_q <= ST_FIN;
					end else if (left_q == '0) begin
						status_q <= STATUS_NONE;
						found_q  <= '0;
						state_q  <= ST_FIN;
					end else begin
						left_q <= left_q - CNT_W'(1);
						addr_q <= (kind_q == KIND_PREV) ? addr_q - ADDR_W'(1) :
							addr_q + ADDR_W'(1);
					end
				end
				ST_FIN: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= OUT_DATA_W'({seq_count, count_q, found_q, status_q});
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/smt_check.sv
// port-level checks for the sorted mark table, bound to the top level
module smt_check (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [smt_pkg::OUT_DATA_W-1:0] m_tdata
);

	import smt_pkg::*;

	logic [STATUS_W-1:0]      o_status;
	logic [POSITION_BITS-1:0] o_found;
	logic [CNT_W-1:0]         o_count;
	logic [SEQ_W-1:0]         o_seq;

	assign o_status = m_tdata[STATUS_W-1:0];
	assign o_found  = m_tdata[COUNT_LSB-1:FOUND_LSB];
	assign o_count  = m_tdata[SEQ_LSB-1:COUNT_LSB];
	assign o_seq    = m_tdata[SEQ_LSB+SEQ_W-1:SEQ_LSB];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command taken while another is in progress");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && o_status == STATUS_FULL |-> o_count == CNT_W'(TABLE_DEPTH))
		else $error("full status with table not full");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && o_status != STATUS_OK |-> o_found == '0)
		else $error("nonzero position on a miss");

	a_empty_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && o_count == '0 |-> o_seq == '0 && o_status != STATUS_OK)
		else $error("empty table reports sequences or a match");

endmodule

bind sorted_mark_table smt_check u_smt_check (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

### sim/tb_sorted_mark_table.sv
// testbench for sorted_mark_table: directed and random commands checked against a behavioral table
module tb_sorted_mark_table;
	import smt_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 4);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic [POSITION_BITS-1:0] position;
	} mark_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic [POSITION_BITS-1:0] found;
		logic [CNT_W-1:0]         marks;
		logic [SEQ_W-1:0]         sequences;
	} mark_reply_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // position
	logic [KIND_W-1:0]     s_tuser = '0;   // kind
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // status, found_position, mark_count, sequence_count

	sorted_mark_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// behavioral copy of the mark table, kept in ascending order
	logic [POSITION_BITS-1:0] mark_store [TABLE_DEPTH];
	int mark_total = 0;

	function automatic int count_runs();
		int distinct;
		distinct = 0;
		for (int i = 0; i < mark_total; i++)
			if (i == 0 || mark_store[i] != mark_store[i-1])
				distinct++;
		// a lone mark at frame zero opens no sequence
		if (distinct == 1 && mark_store[0] == '0)
			return 0;
		return distinct / 2 + distinct % 2;
	endfunction

	function automatic mark_reply_t apply_mark_command(mark_cmd_t cmd);
		mark_reply_t r;
		int slot;
		r.status = STATUS_NONE;
		r.found  = '0;
		case (cmd.kind)
			KIND_INSERT: begin
				if (mark_total >= TABLE_DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					slot = mark_total;
					while (slot > 0 && mark_store[slot-1] > cmd.position) begin
						mark_store[slot] = mark_store[slot-1];
						slot--;
					end
					mark_store[slot] = cmd.position;
					mark_total++;
					r.status = STATUS_OK;
					r.found  = cmd.position;
				end
			end
			KIND_EXACT: begin
				for (int i = 0; i < mark_total; i++)
					if (mark_store[i] == cmd.position) begin
						r.status = STATUS_OK;
						r.found  = cmd.position;
						break;
					end
			end
			KIND_PREV: begin
				for (int i = mark_total - 1; i >= 0; i--)
					if (mark_store[i] < cmd.position) begin
						r.status = STATUS_OK;
						r.found  = mark_store[i];
						break;
					end
			end
			default: begin
				for (int i = 0; i < mark_total; i++)
					if (mark_store[i] > cmd.position) begin
						r.status = STATUS_OK;
						r.found  = mark_store[i];
						break;
					end
			end
		endcase
		r.marks     = CNT_W'(mark_total);
		r.sequences = SEQ_W'(count_runs());
		return r;
	endfunction

	// command generation
	mark_cmd_t command_queue[$];
	logic [POSITION_BITS-1:0] planted[$];
	int total_items = 0;
	int hold_first = -1;
	int hold_second = -1;

	function automatic void queue_command(logic [KIND_W-1:0] k, logic [POSITION_BITS-1:0] p);
		mark_cmd_t c;
		c.kind     = k;
		c.position = p;
		command_queue = {command_queue, c};
		if (k == KIND_INSERT && planted.size() < TABLE_DEPTH)
			planted = {planted, p};
	endfunction

	function automatic logic [POSITION_BITS-1:0] pick_position();
		int unsigned mode;
		logic [POSITION_BITS-1:0] base;
		mode = $urandom_range(99);
		if (mode < 30)
			return POSITION_BITS'($urandom());
		if (mode < 48)
			return POSITION_BITS'($urandom_range(15));
		if (mode < 58) begin
			case ($urandom_range(3))
				0:       return '0;
				1:       return POSITION_BITS'(1);
				2:       return POS_MAX - POSITION_BITS'(1);
				default: return POS_MAX;
			endcase
		end
		if (planted.size() == 0)
			return POSITION_BITS'($urandom());
		// land on or right beside a stored mark so searches hit
		base = planted[$urandom_range(planted.size() - 1)];
		return base + POSITION_BITS'($urandom_range(2)) - POSITION_BITS'(1);
	endfunction

	// sender and receiver pacing by progress through the run
	int loaded_count = 0;
	int outstanding = 0;
	int accepted_in = 0;
	mark_cmd_t next_cmd;

	function automatic int idle_pct(bit sender);
		int third;
		third = (total_items + 2) / 3;
		if (loaded_count < third)
			return sender ? 24 : 48;
		if (loaded_count < 2 * third)
			return sender ? 48 : 24;
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (command_queue.size() == 0 ||
			    ((loaded_count == hold_first || loaded_count == hold_second) &&
			     (s_tvalid || outstanding != 0)) ||
			    $urandom_range(99) < idle_pct(1'b1)) begin
				s_tvalid <= 1'b0;
			end else begin
				next_cmd = command_queue.pop_front();
				s_tvalid     <= 1'b1;
				s_tdata      <= IN_DATA_W'(next_cmd.position);
				s_tuser      <= next_cmd.kind;
				loaded_count <= loaded_count + 1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= $urandom_range(99) >= idle_pct(1'b0);
	end

	// result checking
	mark_reply_t awaited_results[$];
	mark_reply_t want, seen;
	mark_cmd_t taken;
	int error_count = 0;

	task automatic report_field(string field, longint unsigned want_v, longint unsigned got_v);
		if (want_v != got_v) begin
			error_count++;
			if (error_count <= 10)
				$display("mismatch in %s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				taken.kind     = s_tuser;
				taken.position = s_tdata[POSITION_BITS-1:0];
				awaited_results = {awaited_results, apply_mark_command(taken)};
			end
			if (m_tvalid && m_tready) begin
				seen.status    = m_tdata[STATUS_W-1:0];
				seen.found     = m_tdata[COUNT_LSB-1:FOUND_LSB];
				seen.marks     = m_tdata[SEQ_LSB-1:COUNT_LSB];
				seen.sequences = m_tdata[OUT_BITS-1:SEQ_LSB];
				if (awaited_results.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("result transfer with no command waiting: 0x%0h", m_tdata);
				end else begin
					want = awaited_results.pop_front();
					report_field("status", want.status, seen.status);
					report_field("found_position", want.found, seen.found);
					report_field("mark_count", want.marks, seen.marks);
					report_field("sequence_count", want.sequences, seen.sequences);
					report_field("zero fill", 0, m_tdata >> OUT_BITS);
				end
			end
			outstanding <= outstanding + int'(s_tvalid && s_tready) - int'(m_tvalid && m_tready);
			accepted_in <= accepted_in + int'(s_tvalid && s_tready);
		end
	end

	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		// empty table searches, then lone zero marks with duplicates
		queue_command(KIND_EXACT, '0);
		queue_command(KIND_PREV, POS_MAX);
		queue_command(KIND_NEXT, '0);
		queue_command(KIND_INSERT, '0);
		queue_command(KIND_EXACT, '0);
		queue_command(KIND_INSERT, '0);
		queue_command(KIND_PREV, '0);
		queue_command(KIND_NEXT, '0);
		queue_command(KIND_PREV, POSITION_BITS'(1));
		// top of the range, then an odd number of distinct marks
		queue_command(KIND_INSERT, POS_MAX);
		queue_command(KIND_EXACT, POS_MAX);
		queue_command(KIND_PREV, POS_MAX);
		queue_command(KIND_NEXT, '0);
		queue_command(KIND_NEXT, POS_MAX);
		queue_command(KIND_INSERT, POSITION_BITS'(5));
		queue_command(KIND_PREV, POSITION_BITS'(5));
		queue_command(KIND_NEXT, POSITION_BITS'(5));
		queue_command(KIND_EXACT, POSITION_BITS'(6));
		queue_command(KIND_INSERT, POSITION_BITS'(5));
		queue_command(KIND_INSERT, POSITION_BITS'('hAAAAAA));
		queue_command(KIND_INSERT, POSITION_BITS'('h555555));
		queue_command(KIND_EXACT, POSITION_BITS'('h555555));
		hold_first = command_queue.size();

		// sparse inserts fill the table around two thirds through the run
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(99) < 5)
				queue_command(KIND_INSERT, pick_position());
			else
				queue_command(KIND_W'(1 + $urandom_range(2)), pick_position());
		end
		total_items = command_queue.size();
		hold_second = hold_first + RANDOM_ITEMS / 2;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (accepted_in != total_items || outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && awaited_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### files.f
rtl/smt_pkg.sv
rtl/smt_ram.sv
rtl/sorted_mark_table.sv
rtl/smt_check.sv
sim/tb_sorted_mark_table.sv
